>>> src/mkp_pkg.sv
// ----------------------------------------------------------------------------
// mkp_pkg: shared types and constants of the matrix keypad model
// Field widths, operation and register codes, bounce timing constants and
// the payload structs carried by the item channels.
// ----------------------------------------------------------------------------
package mkp_pkg;

  // Default matrix limits, handed to the top level parameters
  localparam int MAX_COLUMNS_DEFAULT = 8;
  localparam int MAX_ROWS_DEFAULT    = 8;

  // Field widths
  localparam int LINE_W     = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int LAST_KEY_W = 2 * KEY_IDX_W;
  localparam int OP_W       = 2;
  localparam int DRAW_W     = 9;
  localparam int NS_W       = 10;
  localparam int CNT_W      = 4;
  localparam int CLK_HZ_W   = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CLK_HZ_W;

  // Bounce length arithmetic: product of bounce time and clock, and the
  // signed residual that tracks it against the divisor
  localparam int PROD_W = NS_W + CLK_HZ_W;
  localparam int RES_W  = PROD_W + 1;

  // Bounce timing constants
  localparam int BOUNCE_BASE_NS  = 500;
  localparam int BOUNCE_DRAW_MAX = 500;
  localparam int CLOCK_DIVISOR   = 6;
  localparam int NS_SCALE        = 1000000;
  localparam int TICK_STEP       = 2;
  localparam int BOUNCE_DIVISOR  = CLOCK_DIVISOR * NS_SCALE;

  localparam logic signed [RES_W-1:0] DIV_RES  = RES_W'(BOUNCE_DIVISOR);
  localparam logic signed [RES_W-1:0] TICK_RES = RES_W'(TICK_STEP * BOUNCE_DIVISOR);

  // Register reset values
  localparam int COLUMN_COUNT_RESET = 4;
  localparam int ROW_COUNT_RESET    = 4;
  localparam int CLOCK_HZ_RESET     = 1000000;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_DRIVE_ROWS = 2'd0,
    OP_KEY_EVENT  = 2'd1,
    OP_TICK       = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREE_LEVEL    = 3'd0,
    REG_TOGGLE_MODE   = 3'd1,
    REG_BOUNCE_ENABLE = 3'd2,
    REG_COLUMN_COUNT  = 3'd3,
    REG_ROW_COUNT     = 3'd4,
    REG_CLOCK_HZ      = 3'd5
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [LINE_W-1:0]    row_lines;
    logic [KEY_IDX_W-1:0] key_column;
    logic [KEY_IDX_W-1:0] key_row;
    logic                 key_down;
    logic [DRAW_W-1:0]    bounce_draw;
    logic                 noise_bit;
  } mkp_in_t;

  // Result item
  typedef struct packed {
    logic [LINE_W-1:0] column_lines;
    logic              changed;
    logic              bouncing;
  } mkp_out_t;

endpackage

>>> src/mkp_stream_if.sv
// ----------------------------------------------------------------------------
// mkp_stream_if: valid/ready item channel
// Carries one payload per transfer; a transfer happens at a rising clock
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mkp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (
    output valid,
    output data,
    input  ready
  );

  modport sink (
    input  valid,
    input  data,
    output ready
  );

endinterface

>>> src/matrix_keypad_model.sv
// ----------------------------------------------------------------------------
// matrix_keypad_model: key matrix with contact bounce
// Keeps a pressed bit per key, the row levels, the last changed key and the
// bounce state, and reports the column line levels after every item.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns exactly one result per item:
// the item is first held in an input register, then the key update, the column
// evaluation over the whole matrix and the 10 x 27 bit bounce product are done
// combinationally into the result register. The sustained rate is one item
// per clock, set by that single compute stage; the input side stops only while
// a result waits at the output and the next one is already held. The bounce
// countdown is kept as a signed residual of the bounce product less the
// bounce divisor, lowered while not negative by the divisor times the tick
// step on every tick; the key bounces while the residual is not negative.
// Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module matrix_keypad_model #(
  parameter int MAX_COLUMNS = mkp_pkg::MAX_COLUMNS_DEFAULT,
  parameter int MAX_ROWS    = mkp_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mkp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkp_pkg::CFG_DATA_W-1:0] cfg_data,
  mkp_stream_if.sink                    in_ch,
  mkp_stream_if.source                  out_ch
);

  import mkp_pkg::*;

  // Key storage is bounded by the matrix limits and by the key index range
  localparam int KEY_COLS = (MAX_COLUMNS < LINE_W) ? MAX_COLUMNS : LINE_W;
  localparam int KEY_ROWS = (MAX_ROWS < LINE_W) ? MAX_ROWS : LINE_W;

  // Configuration registers
  logic                free_level;
  logic                toggle_mode;
  logic                bounce_enable;
  logic [CNT_W-1:0]    column_count;
  logic [CNT_W-1:0]    row_count;
  logic [CLK_HZ_W-1:0] clock_hz;

  // Keypad state
  logic                    key_pressed [KEY_COLS][KEY_ROWS];
  logic [LINE_W-1:0]       row_levels;
  logic [LAST_KEY_W-1:0]   last_key;
  logic signed [RES_W-1:0] residual;
  logic [LINE_W-1:0]       last_columns;

  logic                    key_next [KEY_COLS][KEY_ROWS];
  logic [LINE_W-1:0]       row_levels_next;
  logic [LAST_KEY_W-1:0]   last_key_next;
  logic signed [RES_W-1:0] residual_next;
  logic [LINE_W-1:0]       columns_next;
  logic                    bouncing_next;

  // Pipeline registers
  logic     s1_valid;
  mkp_in_t  s1_data;
  logic     out_valid;
  mkp_out_t out_data;

  logic s2_free;
  logic advance;

  // Derived lines in use and bounce product
  logic [LINE_W-1:0] col_used;
  logic [LINE_W-1:0] row_used;
  logic              key_in_range;
  logic [DRAW_W-1:0] draw_clamped;
  logic [NS_W-1:0]   bounce_ns;
  logic [PROD_W-1:0] bounce_prod;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_level    <= 1'b0;
      toggle_mode   <= 1'b0;
      bounce_enable <= 1'b0;
      column_count  <= CNT_W'(COLUMN_COUNT_RESET);
      row_count     <= CNT_W'(ROW_COUNT_RESET);
      clock_hz      <= CLK_HZ_W'(CLOCK_HZ_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREE_LEVEL:    free_level    <= cfg_data[0];
        REG_TOGGLE_MODE:   toggle_mode   <= cfg_data[0];
        REG_BOUNCE_ENABLE: bounce_enable <= cfg_data[0];
        REG_COLUMN_COUNT:  column_count  <= cfg_data[CNT_W-1:0];
        REG_ROW_COUNT:     row_count     <= cfg_data[CNT_W-1:0];
        REG_CLOCK_HZ:      clock_hz      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register moves on when the result register is free
  assign s2_free      = !out_valid || out_ch.ready;
  assign advance      = s1_valid && s2_free;
  assign in_ch.ready  = !s1_valid || s2_free;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Capture input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data <= in_ch.data;
    end
  end

  // Mark columns and rows in use, saturated at the matrix limits
  always_comb begin
    for (int i = 0; i < LINE_W; i++) begin
      col_used[i] = (i < MAX_COLUMNS) && (i < int'(column_count));
      row_used[i] = (i < MAX_ROWS) && (i < int'(row_count));
    end
  end

  assign key_in_range = col_used[s1_data.key_column] && row_used[s1_data.key_row];

  // Bounce time in ns times the clock frequency
  assign draw_clamped = (s1_data.bounce_draw > DRAW_W'(BOUNCE_DRAW_MAX)) ?
                        DRAW_W'(BOUNCE_DRAW_MAX) : s1_data.bounce_draw;
  assign bounce_ns    = NS_W'(BOUNCE_BASE_NS) + NS_W'(draw_clamped);
  assign bounce_prod  = PROD_W'(bounce_ns) * PROD_W'(clock_hz);

  // Apply the operation to the keypad state
  always_comb begin
    key_next        = key_pressed;
    row_levels_next = row_levels;
    last_key_next   = last_key;
    residual_next   = residual;
    unique case (s1_data.operation)
      OP_DRIVE_ROWS: begin
        row_levels_next = s1_data.row_lines & row_used;
      end
      OP_KEY_EVENT: begin
        if (key_in_range) begin
          if (!toggle_mode || s1_data.key_down) begin
            last_key_next = {s1_data.key_row, s1_data.key_column};
          end
          for (int x = 0; x < KEY_COLS; x++) begin
            for (int y = 0; y < KEY_ROWS; y++) begin
              if (x == int'(s1_data.key_column) && y == int'(s1_data.key_row)) begin
                if (!toggle_mode) begin
                  key_next[x][y] = s1_data.key_down;
                end else if (s1_data.key_down) begin
                  key_next[x][y] = !key_pressed[x][y];
                end
              end
            end
          end
          if (bounce_enable) begin
            residual_next = $signed({1'b0, bounce_prod}) - DIV_RES;
          end
        end
      end
      OP_TICK: begin
        if (!residual[RES_W-1]) begin
          residual_next = residual - TICK_RES;
        end
      end
      default: begin
      end
    endcase
  end

  assign bouncing_next = !residual_next[RES_W-1];

  // Evaluate column levels; the bouncing key reads the noise bit
  always_comb begin
    logic ps;
    logic pull;
    ps   = 1'b0;
    pull = 1'b0;
    columns_next = {LINE_W{free_level}};
    for (int x = 0; x < KEY_COLS; x++) begin
      pull = 1'b0;
      for (int y = 0; y < KEY_ROWS; y++) begin
        if (bouncing_next &&
            last_key_next == {KEY_IDX_W'(y), KEY_IDX_W'(x)}) begin
          ps = s1_data.noise_bit;
        end else begin
          ps = key_next[x][y];
        end
        if (row_used[y]) begin
          if (free_level) begin
            pull = pull | (ps & !row_levels_next[y]);
          end else begin
            pull = pull | (ps & row_levels_next[y]);
          end
        end
      end
      if (col_used[x]) begin
        columns_next[x] = free_level ? !pull : pull;
      end
    end
  end

  // Advance keypad state
  always_ff @(posedge clk) begin
    if (rst) begin
      key_pressed  <= '{default: '{default: 1'b0}};
      row_levels   <= '0;
      last_key     <= '0;
      residual     <= '1;
      last_columns <= '0;
    end else if (advance) begin
      key_pressed  <= key_next;
      row_levels   <= row_levels_next;
      last_key     <= last_key_next;
      residual     <= residual_next;
      last_columns <= columns_next;
    end
  end

  // Hold result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.column_lines <= columns_next;
      out_data.changed      <= (columns_next != last_columns);
      out_data.bouncing     <= bouncing_next;
    end
  end

  // A tick with no bounce running reports no bounce
  a_tick_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.operation == OP_TICK && residual[RES_W-1])
      |=> !out_data.bouncing)
    else $error("tick started a bounce period");

  // The changed flag compares against the previous result
  a_changed: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_data.changed == (out_data.column_lines != $past(last_columns))))
    else $error("changed flag does not match column history");

  // Only key events move the last changed key
  a_last_key: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.operation != OP_KEY_EVENT) |=> $stable(last_key))
    else $error("last key moved without a key event");

  // With bounce disabled a key event leaves the bounce state alone
  a_bounce_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_data.operation == OP_KEY_EVENT && !bounce_enable)
      |=> $stable(residual))
    else $error("bounce state changed with bounce disabled");

endmodule
